@@ hw/rtl/md5_pkg.sv @@
// md5_pkg: shared types, round constants and helper functions of the MD5 engine.
// No dependencies; compiled first.
package md5_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic {
    F_ACCEPT,
    F_PAD
  } front_state_e;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_FINAL,
    B_OUT
  } back_state_e;

  // One little-endian message word plus block and message boundary marks.
  typedef struct packed {
    logic [31:0] word;
    logic        blk_last;
    logic        msg_last;
  } qword_t;

  typedef struct packed {
    logic   valid;
    qword_t data;
  } qpush_t;

  localparam logic [3:0][31:0] InitChain = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RoundS [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [4:0] shift_amt(input logic [5:0] rnd);
    return RoundS[{rnd[5:4], rnd[1:0]}];
  endfunction

  // Message word used by a round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i4;
    logic [3:0] idx;
    i4 = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = i4;
      2'd1:    idx = (i4 << 2) + i4 + 4'd1;
      2'd2:    idx = (i4 << 1) + i4 + 4'd5;
      2'd3:    idx = (i4 << 3) - i4;
      default: idx = i4;
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

@@ hw/rtl/md5_if.sv @@
// md5_if: valid/ready channel interfaces for message items and digest results.
// No dependencies.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        last_word;

  modport source (output valid, digest_word, last_word, input ready);
  modport sink   (input valid, digest_word, last_word, output ready);
endinterface

@@ hw/rtl/md5_digest_engine.sv @@
// md5_digest_engine: MD5 over a byte stream, one byte item per cycle at the front while
// the word queue has room and no padding is under way. Round engine: 16 word loads, 64
// rounds and one chain update per block; the 4-word queue holds only 16 bytes during the
// rounds, so a steady stream stalls at the front while a block is hashed. End item: 3 to
// 18 pad words; the first digest result is valid after the last padded block is hashed,
// the second once the first is taken. Async active-low reset clears control state.
module md5_digest_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);
  import md5_pkg::*;

  qpush_t push;
  qword_t pop_data;
  logic   q_full;
  logic   pop_valid;
  logic   pop_ready;

  md5_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push)
  );

  md5_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (q_full),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_ready_i (pop_ready)
  );

  md5_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

  a_no_ready_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_full |-> !in_i.ready
  ) else $error("input ready while word queue is full");

  a_no_push_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) push.valid |-> !q_full
  ) else $error("front pushed into a full word queue");

  a_second_half_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last_word) |=> (out_o.valid && out_o.last_word)
  ) else $error("second digest half did not follow the first");

  a_msg_end_closes_block: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (push.valid && push.data.msg_last) |-> push.data.blk_last
  ) else $error("message end marked on a word that does not close a block");

endmodule

@@ hw/rtl/md5_front.sv @@
// md5_front: accepts byte items, packs little-endian words, counts bits and
// generates padding and length words. Depends on md5_pkg and md5_in_if.
module md5_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  md5_in_if.sink          in_i,
  input  logic            full_i,
  output md5_pkg::qpush_t push_o
);
  import md5_pkg::*;

  front_state_e state_q, state_d;
  logic [5:0]   pos_q, pos_d;
  logic [31:0]  word_q, word_d;
  logic [63:0]  total_q, total_d;
  logic [3:0]   pw_q, pw_d;
  logic         first_q, first_d;
  logic         lenblk_q, lenblk_d;
  logic         accept;
  logic [31:0]  byte_word;

  assign in_i.ready = (state_q == F_ACCEPT) && !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign byte_word  = (pos_q[1:0] == 2'd0) ? {24'd0, in_i.data_byte}
                    : (word_q | ({24'd0, in_i.data_byte} << {pos_q[1:0], 3'b000}));

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    word_d   = word_q;
    total_d  = total_q;
    pw_d     = pw_q;
    first_d  = first_q;
    lenblk_d = lenblk_q;
    push_o   = '0;
    case (state_q)
      F_ACCEPT: begin
        if (accept) begin
          if (in_i.byte_present) begin
            word_d  = byte_word;
            pos_d   = pos_q + 6'd1;
            total_d = total_q + 64'd8;
            if (pos_q[1:0] == 2'd3) begin
              push_o.valid         = 1'b1;
              push_o.data.word     = byte_word;
              push_o.data.blk_last = (pos_q == 6'd63);
            end
          end
          if (in_i.end_of_message) begin
            state_d  = F_PAD;
            pw_d     = pos_d[5:2];
            first_d  = 1'b1;
            // length fits in this block only below byte 56
            lenblk_d = (pos_d[5:3] != 3'b111);
          end
        end
      end
      F_PAD: begin
        if (!full_i) begin
          push_o.valid = 1'b1;
          if (first_q) begin
            push_o.data.word = (pos_q[1:0] == 2'd0) ? 32'h0000_0080
                             : (word_q | (32'h0000_0080 << {pos_q[1:0], 3'b000}));
            first_d = 1'b0;
          end else if (lenblk_q && pw_q == 4'd14) begin
            push_o.data.word = total_q[31:0];
          end else if (lenblk_q && pw_q == 4'd15) begin
            push_o.data.word = total_q[63:32];
          end
          push_o.data.blk_last = (pw_q == 4'd15);
          push_o.data.msg_last = (pw_q == 4'd15) && lenblk_q;
          pw_d = pw_q + 4'd1;
          if (pw_q == 4'd15) begin
            if (lenblk_q) begin
              state_d = F_ACCEPT;
              pos_d   = '0;
              total_d = '0;
            end else begin
              lenblk_d = 1'b1;
            end
          end
        end
      end
      default: state_d = F_ACCEPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_ACCEPT;
      pos_q    <= '0;
      total_q  <= '0;
      pw_q     <= '0;
      first_q  <= 1'b0;
      lenblk_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
      pw_q     <= pw_d;
      first_q  <= first_d;
      lenblk_q <= lenblk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

@@ hw/rtl/md5_fifo.sv @@
// md5_fifo: short word queue between the front and the round engine.
// Depends on md5_pkg.
module md5_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  md5_pkg::qpush_t push_i,
  output logic            full_o,
  output logic            pop_valid_o,
  output md5_pkg::qword_t pop_data_o,
  input  logic            pop_ready_i
);
  import md5_pkg::*;

  qword_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == (QPtrW + 1)'(QDepth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.data;
  end

endmodule

@@ hw/rtl/md5_core.sv @@
// md5_core: loads 16 words, runs 64 MD5 rounds one per cycle, updates the chain
// and emits the digest in two results. Depends on md5_pkg and md5_out_if.
module md5_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  md5_pkg::qword_t pop_data_i,
  output logic            pop_ready_o,
  md5_out_if.source       out_o
);
  import md5_pkg::*;

  back_state_e      state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [5:0]       round_q, round_d;
  logic             msg_q, msg_d;
  logic [31:0]      m_q [16];
  logic [31:0]      a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [31:0]      pre_q, pre_d;
  logic [3:0][31:0] chain_q, chain_d;
  logic [3:0][31:0] chain_sum;
  logic             ov_q, ov_d, ol_q, ol_d;
  logic [63:0]      od_q, od_d;
  logic             m_we;
  logic [31:0]      sum;
  logic [31:0]      new_b;
  logic [5:0]       next_round;

  assign pop_ready_o       = (state_q == B_LOAD);
  assign m_we              = pop_valid_i && pop_ready_o;
  assign out_o.valid       = ov_q;
  assign out_o.digest_word = od_q;
  assign out_o.last_word   = ol_q;

  assign sum        = a_q + round_f(round_q[5:4], b_q, c_q, d_q) + pre_q;
  assign new_b      = b_q + rotl32(sum, shift_amt(round_q));
  assign next_round = round_q + 6'd1;
  assign chain_sum  = {chain_q[3] + d_q, chain_q[2] + c_q, chain_q[1] + b_q, chain_q[0] + a_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    round_d = round_q;
    msg_d   = msg_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    pre_d   = pre_q;
    chain_d = chain_q;
    ov_d    = ov_q;
    ol_d    = ol_q;
    od_d    = od_q;
    case (state_q)
      B_LOAD: begin
        if (m_we) begin
          cnt_d = cnt_q + 4'd1;
          if (pop_data_i.blk_last) begin
            state_d = B_ROUND;
            cnt_d   = '0;
            msg_d   = pop_data_i.msg_last;
            round_d = '0;
            a_d     = chain_q[0];
            b_d     = chain_q[1];
            c_d     = chain_q[2];
            d_d     = chain_q[3];
            // word 0 is already stored when the last word arrives
            pre_d   = m_q[0] + RoundK[0];
          end
        end
      end
      B_ROUND: begin
        a_d     = d_q;
        b_d     = new_b;
        c_d     = b_q;
        d_d     = c_q;
        pre_d   = m_q[msg_index(next_round)] + RoundK[next_round];
        round_d = next_round;
        if (round_q == 6'd63) state_d = B_FINAL;
      end
      B_FINAL: begin
        chain_d = chain_sum;
        if (msg_q) begin
          ov_d    = 1'b1;
          ol_d    = 1'b0;
          od_d    = {bswap32(chain_sum[0]), bswap32(chain_sum[1])};
          state_d = B_OUT;
        end else begin
          state_d = B_LOAD;
        end
      end
      B_OUT: begin
        if (out_o.ready) begin
          if (!ol_q) begin
            ol_d = 1'b1;
            od_d = {bswap32(chain_q[2]), bswap32(chain_q[3])};
          end else begin
            ov_d    = 1'b0;
            chain_d = InitChain;
            state_d = B_LOAD;
          end
        end
      end
      default: state_d = B_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_LOAD;
      cnt_q   <= '0;
      round_q <= '0;
      msg_q   <= 1'b0;
      chain_q <= InitChain;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      round_q <= round_d;
      msg_q   <= msg_d;
      chain_q <= chain_d;
      ov_q    <= ov_d;
      ol_q    <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    pre_q <= pre_d;
    od_q  <= od_d;
    if (m_we) m_q[cnt_q] <= pop_data_i.word;
  end

endmodule
